>>> design/assert_macros.svh
// assertion macros used by sorted_key_node_table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/skn_pkg.sv
// types, constants and key compare for the sorted key node table
package skn_pkg;
  localparam int NODE_CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int ADDR_W = $clog2(NODE_CAPACITY);
  localparam int CNT_W = $clog2(NODE_CAPACITY + 1);
  localparam int IDX_W = CNT_W + 1;

  typedef enum logic [2:0] {
    CMD_SORTED_INS = 3'd0,
    CMD_INSERT_AT  = 3'd1,
    CMD_ERASE      = 3'd2,
    CMD_SEARCH     = 3'd3,
    CMD_LOWER      = 3'd4,
    CMD_INS_POS    = 3'd5,
    CMD_SRCH_POS   = 3'd6,
    CMD_READ       = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD      = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KT_SIGNED = 2'd0,
    KT_FLOAT  = 2'd1,
    KT_BYTES  = 2'd2
  } key_type_t;

  typedef enum logic [1:0] {
    CMP_LT,
    CMP_EQ,
    CMP_GT
  } cmp_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [31:0]        key;
    logic signed [31:0] rid_page;
    logic signed [15:0] rid_slot;
    logic [6:0]         position;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [7:0]  found_index;
    logic [31:0]        key_out;
    logic signed [31:0] rid_page_out;
    logic signed [15:0] rid_slot_out;
    logic [6:0]         entry_count;
  } out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [31:0]         page;
    logic [15:0]         slot;
  } entry_t;

  function automatic logic [KEY_BITS-1:0] key_map(logic [KEY_BITS-1:0] k, logic [1:0] kt);
    logic [KEY_BITS-1:0] r;
    case (kt)
      KT_SIGNED: r = k ^ {1'b1, {(KEY_BITS-1){1'b0}}};
      KT_FLOAT:  r = k[KEY_BITS-1] ? ~k : (k | {1'b1, {(KEY_BITS-1){1'b0}}});
      default:   r = k;
    endcase
    return r;
  endfunction

  function automatic cmp_t key_cmp(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b,
                                   logic [1:0] kt);
    logic [KEY_BITS-1:0] ma;
    logic [KEY_BITS-1:0] mb;
    cmp_t r;
    ma = key_map(a, kt);
    mb = key_map(b, kt);
    if (kt == KT_FLOAT && a[KEY_BITS-2:0] == '0 && b[KEY_BITS-2:0] == '0) r = CMP_EQ;
    else if (ma > mb) r = CMP_GT;
    else if (ma < mb) r = CMP_LT;
    else r = CMP_EQ;
    return r;
  endfunction
endpackage

>>> design/skn_ram.sv
// generic single write port ram with registered read
module skn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> design/sorted_key_node_table.sv
// sorted key node table: sequencer over one entry ram and one key comparator
//
//  channel  | signals                  | dir
//  request  | in_valid in_stall in_req | in
//  result   | out_valid out_stall out_rsp | out
//  config   | cfg_we cfg_data          | in
//
// one request at a time; each step is a ram read followed by a compare
// searches: a binary search, then a walk over equal keys or a single compare
// inserts and erases: entries are moved one at a time
// reset clears count and key type; entry ram content is undefined until written
// a finished result waits in the output register while a new request is taken
`include "assert_macros.svh"
module sorted_key_node_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  skn_pkg::in_t in_req,
  output logic         out_valid,
  input  logic         out_stall,
  output skn_pkg::out_t out_rsp,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_data
);
  import skn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_CHK, S_INS_CMP, S_INS_PUT, S_ERA_CHK, S_ERA_CMP,
    S_RD_ISSUE, S_RD_TAKE, S_BS_CHK, S_BS_CMP, S_ONE_CMP, S_SR_CHK,
    S_SR_CMP, S_DONE
  } state_t;

  state_t                   state;
  logic [1:0]               key_type;
  logic [CNT_W-1:0]         used;
  cmd_t                     cmd;
  logic [KEY_BITS-1:0]      key;
  logic [31:0]              page;
  logic [15:0]              slot;
  logic [CNT_W-1:0]         pos;
  logic [CNT_W-1:0]         i;
  logic signed [IDX_W-1:0]  lo;
  logic signed [IDX_W-1:0]  hi;
  logic [ADDR_W-1:0]        mid;
  status_t                  res_status;
  logic signed [IDX_W-1:0]  res_idx;
  logic [31:0]              res_key;
  logic [31:0]              res_page;
  logic [15:0]              res_slot;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  entry_t                   ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                   rd;
  logic [IDX_W:0]           mid_sum;
  logic [ADDR_W-1:0]        mid_next;
  logic signed [IDX_W-1:0]  used_s;
  cmp_t                     cmp_rk;

  skn_ram #(.WIDTH($bits(entry_t)), .DEPTH(NODE_CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);
  assign in_stall = (state != S_IDLE);
  assign used_s = signed'({1'b0, used});
  assign mid_sum = {lo[IDX_W-1], lo} + {hi[IDX_W-1], hi};
  assign mid_next = mid_sum[ADDR_W:1];
  assign cmp_rk = key_cmp(rd.key, key, key_type);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = i[ADDR_W-1:0];
    ram_wdata = rd;
    ram_raddr = i[ADDR_W-1:0];
    case (state)
      S_INS_CHK: ram_raddr = ADDR_W'(i - 1'b1);
      S_INS_CMP: ram_we = (cmd == CMD_INSERT_AT) || (cmp_rk != CMP_LT);
      S_INS_PUT: begin
        ram_we = 1'b1;
        ram_wdata = '{key: key, page: page, slot: slot};
      end
      S_ERA_CHK: ram_raddr = ADDR_W'(i + 1'b1);
      S_ERA_CMP: ram_we = 1'b1;
      S_RD_ISSUE: ram_raddr = pos[ADDR_W-1:0];
      S_BS_CHK: ram_raddr = (lo <= hi) ? mid_next : lo[ADDR_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      key_type <= KT_SIGNED;
      used <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) key_type <= cfg_data;
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          cmd <= in_req.cmd;
          key <= in_req.key[KEY_BITS-1:0];
          page <= in_req.rid_page;
          slot <= in_req.rid_slot;
          pos <= in_req.position;
          res_idx <= '1;
          res_key <= '0;
          res_page <= '1;
          res_slot <= '1;
          i <= (in_req.cmd == CMD_ERASE) ? in_req.position : used;
          lo <= '0;
          hi <= used_s - 1'b1;
          case (in_req.cmd)
            CMD_SORTED_INS, CMD_INSERT_AT: begin
              if (used == CNT_W'(NODE_CAPACITY) ||
                  (in_req.cmd == CMD_INSERT_AT && in_req.position > used)) begin
                res_status <= ST_BAD;
                state <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state <= S_INS_CHK;
              end
            end
            CMD_ERASE: begin
              if (in_req.position >= used) begin
                res_status <= ST_BAD;
                state <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state <= S_ERA_CHK;
              end
            end
            CMD_READ: begin
              if (in_req.position >= used) begin
                res_status <= ST_BAD;
                state <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state <= S_RD_ISSUE;
              end
            end
            default: begin
              res_status <= ST_OK;
              state <= S_BS_CHK;
            end
          endcase
        end
        S_INS_CHK: begin
          if (i == '0 || (cmd == CMD_INSERT_AT && i == pos)) state <= S_INS_PUT;
          else state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (cmd == CMD_INSERT_AT || cmp_rk != CMP_LT) begin
            i <= i - 1'b1;
            state <= S_INS_CHK;
          end else state <= S_INS_PUT;
        end
        S_INS_PUT: begin
          used <= used + 1'b1;
          res_idx <= signed'({1'b0, i});
          state <= S_DONE;
        end
        S_ERA_CHK: begin
          if (i + 1'b1 >= used) begin
            used <= used - 1'b1;
            res_idx <= signed'({1'b0, pos});
            state <= S_DONE;
          end else state <= S_ERA_CMP;
        end
        S_ERA_CMP: begin
          i <= i + 1'b1;
          state <= S_ERA_CHK;
        end
        S_RD_ISSUE: state <= S_RD_TAKE;
        S_RD_TAKE: begin
          res_idx <= signed'({1'b0, pos});
          res_key <= 32'(rd.key);
          res_page <= rd.page;
          res_slot <= rd.slot;
          state <= S_DONE;
        end
        S_BS_CHK: begin
          if (lo <= hi) begin
            mid <= mid_next;
            state <= S_BS_CMP;
          end else begin
            i <= lo[CNT_W-1:0];
            case (cmd)
              CMD_INS_POS: begin
                res_idx <= lo;
                state <= S_DONE;
              end
              CMD_SRCH_POS: begin
                if (lo >= used_s) begin
                  res_idx <= used_s - 1'b1;
                  if (used == '0) res_status <= ST_NOTFOUND;
                  state <= S_DONE;
                end else if (lo == '0) state <= S_ONE_CMP;
                else begin
                  res_idx <= lo - 1'b1;
                  state <= S_DONE;
                end
              end
              CMD_LOWER: begin
                if (lo >= used_s) begin
                  res_status <= ST_NOTFOUND;
                  state <= S_DONE;
                end else state <= S_ONE_CMP;
              end
              default: state <= S_SR_CHK;
            endcase
          end
        end
        S_BS_CMP: begin
          if (cmp_rk == CMP_LT) lo <= signed'({1'b0, CNT_W'(mid)}) + 1'b1;
          else hi <= signed'({1'b0, CNT_W'(mid)}) - 1'b1;
          state <= S_BS_CHK;
        end
        S_ONE_CMP: begin
          if (cmd == CMD_SRCH_POS) begin
            if (cmp_rk == CMP_GT) res_status <= ST_NOTFOUND;
            else res_idx <= '0;
          end else begin
            if (cmp_rk == CMP_EQ) res_idx <= lo;
            else res_status <= ST_NOTFOUND;
          end
          state <= S_DONE;
        end
        S_SR_CHK: begin
          if (i >= used) begin
            res_status <= ST_NOTFOUND;
            state <= S_DONE;
          end else state <= S_SR_CMP;
        end
        S_SR_CMP: begin
          if (cmp_rk != CMP_EQ) begin
            res_status <= ST_NOTFOUND;
            state <= S_DONE;
          end else if (rd.page == page && rd.slot == slot) begin
            res_idx <= signed'({1'b0, i});
            state <= S_DONE;
          end else begin
            i <= i + 1'b1;
            state <= S_SR_CHK;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_rsp.status <= res_status;
            out_rsp.found_index <= res_idx;
            out_rsp.key_out <= res_key;
            out_rsp.rid_page_out <= res_page;
            out_rsp.rid_slot_out <= res_slot;
            out_rsp.entry_count <= used;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NXT(a_accept_busy, clk, rst, in_valid && !in_stall, state != S_IDLE)
  `ASSERT_IMP(a_count_range, clk, rst, 1'b1, used <= CNT_W'(NODE_CAPACITY))
  `ASSERT_IMP(a_write_busy, clk, rst, ram_we, state != S_IDLE && state != S_DONE)
endmodule
